[rtl/online_top_k_threshold_selector_top_macros.svh]
// assertion helpers for the top-k selector
// the enclosing module must provide clk and arst_n
`ifndef ONLINE_TOP_K_THRESHOLD_SELECTOR_TOP_MACROS_SVH
`define ONLINE_TOP_K_THRESHOLD_SELECTOR_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define OTKTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define OTKTS_NEVER(label, cond, msg) \
	`OTKTS_ASSERT(label, !(cond), msg)

`endif

[rtl/otkts_pkg.sv]
`timescale 1ns / 1ps

package otkts_pkg;

	// sizing of the top list and of values
	localparam int MAX_SELECT = 64;
	localparam int VALUE_BITS = 16;
	localparam int SEL_W      = $clog2(MAX_SELECT + 1);
	localparam int IDX_W      = $clog2(MAX_SELECT);
	localparam int SEEN_W     = 16;
	localparam int SUM_W      = 22;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SELECT_COUNT = 8'd0,
		REG_SAMPLE_COUNT = 8'd1
	} cfg_reg_t;

	// operation applied to every cell of the list in the same cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE,
		CELL_CLEAR
	} cell_op_t;

	// one result item
	typedef struct packed {
		logic             taken;
		logic [SEL_W-1:0] taken_count;
		logic [SUM_W-1:0] taken_sum;
		logic [SUM_W-1:0] best_sum;
	} res_t;

endpackage

[rtl/otkts_ifs.sv]
`timescale 1ns / 1ps

// input item channel
interface otkts_in_if;
	logic                            valid;
	logic                            ready;
	logic [otkts_pkg::VALUE_BITS-1:0] item_value;
	logic                            last_in_run;

	modport source (output valid, item_value, last_in_run, input ready);
	modport sink   (input valid, item_value, last_in_run, output ready);
endinterface

// result item channel
interface otkts_out_if;
	logic                       valid;
	logic                       ready;
	logic                       taken;
	logic [otkts_pkg::SEL_W-1:0] taken_count;
	logic [otkts_pkg::SUM_W-1:0] taken_sum;
	logic [otkts_pkg::SUM_W-1:0] best_sum;

	modport source (output valid, taken, taken_count, taken_sum, best_sum, input ready);
	modport sink   (input valid, taken, taken_count, taken_sum, best_sum, output ready);
endinterface

// configuration write channel
interface otkts_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [otkts_pkg::CFG_IDX_W-1:0]  index;
	logic [otkts_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/otkts_cell.sv]
`timescale 1ns / 1ps

module otkts_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  otkts_pkg::cell_op_t              op,
	input  logic [otkts_pkg::VALUE_BITS-1:0] item_val,
	input  logic [otkts_pkg::VALUE_BITS-1:0] prev_val,
	input  logic                             prev_ge,
	output logic [otkts_pkg::VALUE_BITS-1:0] val,
	output logic                             ge
);
	import otkts_pkg::*;

	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] val_d;

	// this entry stays where it is when it is not below the new value
	assign ge  = (val_q >= item_val);
	assign val = val_q;

	// next entry value
	always_comb begin
		val_d = val_q;
		unique case (op)
			CELL_HOLD:   val_d = val_q;
			CELL_INSERT: begin
				if (!ge) begin
					val_d = prev_ge ? item_val : prev_val;
				end
			end
			CELL_ROTATE: val_d = prev_val;
			CELL_CLEAR:  val_d = '0;
			default:     val_d = val_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_d;
		end
	end

endmodule

[rtl/otkts_obuf.sv]
`timescale 1ns / 1ps

module otkts_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  otkts_pkg::res_t push_data,
	output logic            full,
	otkts_out_if.source     result
);
	import otkts_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	res_t       head;

	assign pop  = result.valid && result.ready;
	assign full = (cnt_q == 2'd2);
	assign head = slot_q[rd_ptr_q];

	// result channel drive
	assign result.valid       = (cnt_q != 2'd0);
	assign result.taken       = head.taken;
	assign result.taken_count = head.taken_count;
	assign result.taken_sum   = head.taken_sum;
	assign result.best_sum    = head.best_sum;

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[rtl/online_top_k_threshold_selector_top.sv]
// results enter a two-slot output buffer as their items are accepted
// one item per cycle while that buffer has room and no rotation runs; all list
// entries compare and shift in parallel; a select_count write starts a rotation
// of the list that rebuilds the top-k sum and takes no item or register write
// reset (arst_n low): list and run counters clear, select_count 1, sample_count 0
`timescale 1ns / 1ps
`include "online_top_k_threshold_selector_top_macros.svh"

module online_top_k_threshold_selector_top (
	input  logic        clk,
	input  logic        arst_n,
	otkts_in_if.sink    item,
	otkts_out_if.source result,
	otkts_cfg_if.sink   cfg
);
	import otkts_pkg::*;

	// configuration
	logic [SEL_W-1:0]      k_q;
	logic [MAX_SELECT-1:0] kth_q;
	logic [SEEN_W-1:0]     sample_q;

	// run state
	logic [SEEN_W-1:0] seen_q;
	logic [SEL_W-1:0]  taken_q;
	logic [SUM_W-1:0]  taken_sum_q;
	logic [SUM_W-1:0]  best_q;

	// rebuild of the top-k sum
	logic             sweep_q;
	logic [IDX_W-1:0] sweep_cnt_q;
	logic [SUM_W-1:0] sweep_acc_q;

	logic                  item_acc;
	logic                  cfg_acc;
	logic                  buf_full;
	cell_op_t              cell_op;
	logic [VALUE_BITS-1:0] cell_val [MAX_SELECT];
	logic [MAX_SELECT-1:0] cell_ge;
	logic                  hit_kth;
	logic [VALUE_BITS-1:0] kth_val;
	logic                  take;
	logic [SEL_W-1:0]      taken_d;
	logic [SUM_W:0]        tsum_wide;
	logic [SUM_W-1:0]      taken_sum_d;
	logic [SUM_W-1:0]      best_d;
	logic [SEL_W-1:0]      k_wr;
	logic [SEL_W:0]        sweep_pos;
	logic                  sweep_inc;
	logic [SUM_W-1:0]      sweep_acc_d;
	res_t                  res;

	assign item_acc   = item.valid && item.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign item.ready = !buf_full && !sweep_q;
	assign cfg.ready  = !sweep_q;

	// list operation for this cycle
	always_comb begin
		if (item_acc) begin
			cell_op = item.last_in_run ? CELL_CLEAR : CELL_INSERT;
		end else if (sweep_q) begin
			cell_op = CELL_ROTATE;
		end else begin
			cell_op = CELL_HOLD;
		end
	end

	// sorted list, largest first; the first entry takes from the last on rotation
	for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
		otkts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (cell_op),
			.item_val (item.item_value),
			.prev_val (cell_val[(i + MAX_SELECT - 1) % MAX_SELECT]),
			.prev_ge  ((i == 0) ? 1'b1 : cell_ge[(i + MAX_SELECT - 1) % MAX_SELECT]),
			.val      (cell_val[i]),
			.ge       (cell_ge[i])
		);
	end

	// k-th entry and its compare result, picked by the one-hot position
	always_comb begin
		kth_val = '0;
		for (int i = 0; i < MAX_SELECT; i++) begin
			kth_val = kth_val | (kth_q[i] ? cell_val[i] : '0);
		end
		hit_kth = |(kth_q & cell_ge);
	end

	// take decision and running sums
	always_comb begin
		take = (seen_q >= sample_q) && (taken_q < k_q)
			&& ((seen_q < SEEN_W'(k_q)) || !hit_kth);

		taken_d     = taken_q;
		taken_sum_d = taken_sum_q;
		tsum_wide   = {1'b0, taken_sum_q} + (SUM_W + 1)'(item.item_value);
		if (take) begin
			if (taken_q != '1) begin
				taken_d = taken_q + 1'b1;
			end
			taken_sum_d = tsum_wide[SUM_W] ? SUM_MAX : tsum_wide[SUM_W-1:0];
		end

		// new value enters the top k and pushes the old k-th entry out
		best_d = best_q;
		if ((k_q != '0) && !hit_kth) begin
			best_d = best_q + SUM_W'(item.item_value) - SUM_W'(kth_val);
		end

		res.taken       = take;
		res.taken_count = taken_d;
		res.taken_sum   = taken_sum_d;
		res.best_sum    = best_d;
	end

	// effective k of a select_count write
	always_comb begin
		k_wr = cfg.data[SEL_W-1:0];
		if (k_wr > SEL_W'(MAX_SELECT)) begin
			k_wr = SEL_W'(MAX_SELECT);
		end
	end

	// during rotation step j the first cell holds entry (MAX_SELECT - j) mod MAX_SELECT
	always_comb begin
		sweep_pos   = (SEL_W + 1)'(sweep_cnt_q) + (SEL_W + 1)'(k_q);
		sweep_inc   = (k_q != '0)
			&& ((sweep_cnt_q == '0) || (sweep_pos > (SEL_W + 1)'(MAX_SELECT)));
		sweep_acc_d = sweep_acc_q + (sweep_inc ? SUM_W'(cell_val[0]) : '0);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= SEL_W'(1);
			kth_q    <= MAX_SELECT'(1);
			sample_q <= '0;
		end else if (cfg_acc) begin
			if (cfg.index == REG_SELECT_COUNT) begin
				k_q   <= k_wr;
				kth_q <= (k_wr == '0) ? '0 : (MAX_SELECT'(1) << (k_wr - 1'b1));
			end else if (cfg.index == REG_SAMPLE_COUNT) begin
				sample_q <= cfg.data[SEEN_W-1:0];
			end
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			taken_q     <= '0;
			taken_sum_q <= '0;
			best_q      <= '0;
		end else if (item_acc) begin
			if (item.last_in_run) begin
				seen_q      <= '0;
				taken_q     <= '0;
				taken_sum_q <= '0;
				best_q      <= '0;
			end else begin
				if (seen_q != '1) begin
					seen_q <= seen_q + 1'b1;
				end
				taken_q     <= taken_d;
				taken_sum_q <= taken_sum_d;
				best_q      <= best_d;
			end
		end else if (sweep_q && (sweep_cnt_q == IDX_W'(MAX_SELECT - 1))) begin
			best_q <= sweep_acc_d;
		end
	end

	// rebuild sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b0;
			sweep_cnt_q <= '0;
			sweep_acc_q <= '0;
		end else if (cfg_acc && (cfg.index == REG_SELECT_COUNT)) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			sweep_acc_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
			sweep_acc_q <= sweep_acc_d;
			if (sweep_cnt_q == IDX_W'(MAX_SELECT - 1)) begin
				sweep_q <= 1'b0;
			end
		end
	end

	// result buffer
	otkts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_acc),
		.push_data (res),
		.full      (buf_full),
		.result    (result)
	);

	// checks
	`OTKTS_ASSERT(a_kth_onehot, $onehot0(kth_q), "k-th position mark is not one-hot")
	`OTKTS_ASSERT(a_list_sorted, !sweep_q |-> (cell_val[0] >= cell_val[1]), "list out of order")
	`OTKTS_ASSERT(a_run_clears, (item_acc && item.last_in_run) |=> (seen_q == '0), "run not cleared")

endmodule
